// File: src/pgg_pkg.sv
// Package for the Potts grain-growth step engine: grid geometry, field widths,
// operation codes, payload structs and the controller/datapath command structs.
// No dependencies.
package pgg_pkg;

   // Grid geometry and id range
   localparam int GRID_ROWS    = 64;
   localparam int GRID_COLS    = 64;
   localparam int MAX_GRAIN_ID = 255;

   // Field widths
   localparam int OP_W  = 3;
   localparam int ROW_W = 6;
   localparam int COL_W = 6;
   localparam int ID_W  = 8;
   localparam int EN_W  = 4;

   // Cell storage
   localparam int CELL_COUNT = GRID_ROWS * GRID_COLS;
   localparam int CELL_W     = $clog2(CELL_COUNT);

   // 3x3 neighborhood, row-major, center at index NB_CENTER
   localparam int NB_COUNT  = 9;
   localparam int NB_W      = $clog2(NB_COUNT);
   localparam int NB_CENTER = 4;

   // Operation codes
   localparam logic [OP_W-1:0] OP_LOAD  = 3'd0;
   localparam logic [OP_W-1:0] OP_SWEEP = 3'd1;
   localparam logic [OP_W-1:0] OP_VISIT = 3'd2;
   localparam logic [OP_W-1:0] OP_COPY  = 3'd3;
   localparam logic [OP_W-1:0] OP_READ  = 3'd4;

   typedef struct packed {
      logic [OP_W-1:0]  op;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic [ID_W-1:0]  grain_id;
   } req_type;

   typedef struct packed {
      logic [ID_W-1:0] cell_id;
      logic [EN_W-1:0] cell_energy;
      logic            candidate_found;
      logic            flipped;
   } rsp_type;

   // Controller -> datapath commands
   typedef struct packed {
      logic             take_req;   // latch the request, clear visit flags
      logic             probe;      // read one neighborhood position
      logic [NB_W-1:0]  nb_k;       // neighborhood position, row-major
      logic             use_scan;   // probe around the scan cell, else the request cell
      logic             src_snap;   // probes read snapshot ids, else current ids
      logic [ROW_W-1:0] scan_row;
      logic [COL_W-1:0] scan_col;
      logic             eval_sweep; // write energy of the scan cell
      logic             eval_visit; // decide the flip, write back if accepted
      logic             load_wr;    // write the request's id
      logic             copy_rd;    // read current at scan cell for snapshot copy
      logic             load_rsp;   // load the result register
   } cmd_type;

   // Datapath -> controller status
   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            on_grid;
      logic            rsp_free;
   } sts_type;

endpackage

// File: src/pgg_ctrl.sv
// Controller for the Potts grain-growth step engine: request handshake,
// operation sequencing, scan and neighborhood counters.
// Depends on pgg_pkg.
module pgg_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  pgg_pkg::sts_type  sts,
   output pgg_pkg::cmd_type  cmd
);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_DISPATCH = 4'd1;
   localparam logic [3:0] S_PROBE    = 4'd2;
   localparam logic [3:0] S_LAST     = 4'd3;
   localparam logic [3:0] S_EVAL     = 4'd4;
   localparam logic [3:0] S_COPY     = 4'd5;
   localparam logic [3:0] S_DRAIN    = 4'd6;
   localparam logic [3:0] S_LOAD     = 4'd7;
   localparam logic [3:0] S_READ     = 4'd8;
   localparam logic [3:0] S_RESP     = 4'd9;

   localparam logic [pgg_pkg::NB_W-1:0] K_LAST =
      pgg_pkg::NB_W'(pgg_pkg::NB_COUNT - 1);
   localparam logic [pgg_pkg::ROW_W-1:0] ROW_LAST =
      pgg_pkg::ROW_W'(pgg_pkg::GRID_ROWS - 1);
   localparam logic [pgg_pkg::COL_W-1:0] COL_LAST =
      pgg_pkg::COL_W'(pgg_pkg::GRID_COLS - 1);

   logic [3:0]                  state_ff, state_in;
   logic [pgg_pkg::NB_W-1:0]    k_ff, k_in;
   logic [pgg_pkg::ROW_W-1:0]   row_ff, row_in;
   logic [pgg_pkg::COL_W-1:0]   col_ff, col_in;
   logic                        sweep_ff, sweep_in;
   logic                        last_cell;

   assign last_cell = (row_ff == ROW_LAST) && (col_ff == COL_LAST);
   assign req_ready = (state_ff == S_IDLE);

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      k_in         = k_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      sweep_in     = sweep_ff;
      cmd          = '0;
      cmd.nb_k     = k_ff;
      cmd.use_scan = sweep_ff;
      cmd.src_snap = !sweep_ff;
      cmd.scan_row = row_ff;
      cmd.scan_col = col_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.take_req = 1'b1;
               state_in     = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            row_in = '0;
            col_in = '0;
            k_in   = '0;
            priority if (sts.op == pgg_pkg::OP_SWEEP) begin
               sweep_in = 1'b1;
               state_in = S_PROBE;
            end else if (sts.op == pgg_pkg::OP_COPY) begin
               state_in = S_COPY;
            end else if (sts.op == pgg_pkg::OP_LOAD && sts.on_grid) begin
               state_in = S_LOAD;
            end else if (sts.op == pgg_pkg::OP_VISIT && sts.on_grid) begin
               sweep_in = 1'b0;
               state_in = S_PROBE;
            end else begin
               state_in = S_READ;
            end
         end
         S_PROBE: begin
            cmd.probe = 1'b1;
            if (k_ff == K_LAST) begin
               state_in = S_LAST;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         S_LAST: begin
            state_in = S_EVAL;
         end
         S_EVAL: begin
            if (sweep_ff) begin
               cmd.eval_sweep = 1'b1;
               k_in           = '0;
               if (last_cell) begin
                  state_in = S_READ;
               end else begin
                  state_in = S_PROBE;
                  if (col_ff == COL_LAST) begin
                     col_in = '0;
                     row_in = row_ff + 1'b1;
                  end else begin
                     col_in = col_ff + 1'b1;
                  end
               end
            end else begin
               cmd.eval_visit = 1'b1;
               state_in       = S_READ;
            end
         end
         S_COPY: begin
            cmd.copy_rd = 1'b1;
            if (last_cell) begin
               state_in = S_DRAIN;
            end else if (col_ff == COL_LAST) begin
               col_in = '0;
               row_in = row_ff + 1'b1;
            end else begin
               col_in = col_ff + 1'b1;
            end
         end
         S_DRAIN: begin
            state_in = S_READ;
         end
         S_LOAD: begin
            cmd.load_wr = 1'b1;
            state_in    = S_READ;
         end
         S_READ: begin
            state_in = S_RESP;
         end
         S_RESP: begin
            if (sts.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         k_ff     <= '0;
         row_ff   <= '0;
         col_ff   <= '0;
         sweep_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         sweep_ff <= sweep_in;
      end
   end

   // Checks
   a_rsp_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> sts.rsp_free)
      else $error("result loaded while the output register is still held");

   a_visit_ok: assert property (@(posedge clock) disable iff (reset)
      cmd.eval_visit |-> (sts.on_grid && sts.op == pgg_pkg::OP_VISIT))
      else $error("visit evaluated for a non-visit or off-grid request");

   a_take: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_DISPATCH))
      else $error("accepted transfer not dispatched");

   a_k_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PROBE) |-> (k_ff <= K_LAST))
      else $error("neighborhood counter out of range");

endmodule

// File: src/pgg_datapath.sv
// Datapath for the Potts grain-growth step engine: request register, the four
// cell memories, neighborhood taps, unlike counters and the result register.
// Depends on pgg_pkg.
module pgg_datapath (
   input  logic              clock,
   input  logic              reset,
   input  pgg_pkg::cmd_type  cmd,
   output pgg_pkg::sts_type  sts,
   input  pgg_pkg::req_type  req_data,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   output pgg_pkg::rsp_type  rsp_data
);

   localparam logic [pgg_pkg::ROW_W-1:0] ROW_LAST =
      pgg_pkg::ROW_W'(pgg_pkg::GRID_ROWS - 1);
   localparam logic [pgg_pkg::COL_W-1:0] COL_LAST =
      pgg_pkg::COL_W'(pgg_pkg::GRID_COLS - 1);

   function automatic logic [pgg_pkg::CELL_W-1:0] cell_addr(
      input logic [pgg_pkg::ROW_W-1:0] r,
      input logic [pgg_pkg::COL_W-1:0] c
   );
      return pgg_pkg::CELL_W'(r) * pgg_pkg::CELL_W'(pgg_pkg::GRID_COLS)
             + pgg_pkg::CELL_W'(c);
   endfunction

   // Request register
   pgg_pkg::req_type               req_ff;
   logic                           on_grid;
   logic [pgg_pkg::CELL_W-1:0]     req_cell, scan_cell;
   logic [pgg_pkg::ID_W-1:0]       gid_sat;

   always_ff @(posedge clock) begin
      if (cmd.take_req) begin
         req_ff <= req_data;
      end
   end

   assign on_grid = ({1'b0, req_ff.row} < (pgg_pkg::ROW_W + 1)'(pgg_pkg::GRID_ROWS)) &&
                    ({1'b0, req_ff.col} < (pgg_pkg::COL_W + 1)'(pgg_pkg::GRID_COLS));
   assign req_cell  = cell_addr(req_ff.row, req_ff.col);
   assign scan_cell = cell_addr(cmd.scan_row, cmd.scan_col);
   assign gid_sat   = (req_ff.grain_id > pgg_pkg::ID_W'(pgg_pkg::MAX_GRAIN_ID)) ?
                      pgg_pkg::ID_W'(pgg_pkg::MAX_GRAIN_ID) : req_ff.grain_id;

   // Neighbor address: row and column offset from the tap position
   logic [1:0]                 rsel, csel;
   logic [pgg_pkg::ROW_W-1:0]  base_row, nb_row;
   logic [pgg_pkg::COL_W-1:0]  base_col, nb_col;
   logic                       nb_ok;
   logic [pgg_pkg::CELL_W-1:0] nb_addr;

   always_comb begin
      unique case (cmd.nb_k)
         4'd0:    {rsel, csel} = {2'd0, 2'd0};
         4'd1:    {rsel, csel} = {2'd0, 2'd1};
         4'd2:    {rsel, csel} = {2'd0, 2'd2};
         4'd3:    {rsel, csel} = {2'd1, 2'd0};
         4'd5:    {rsel, csel} = {2'd1, 2'd2};
         4'd6:    {rsel, csel} = {2'd2, 2'd0};
         4'd7:    {rsel, csel} = {2'd2, 2'd1};
         4'd8:    {rsel, csel} = {2'd2, 2'd2};
         default: {rsel, csel} = {2'd1, 2'd1};
      endcase
      base_row = cmd.use_scan ? cmd.scan_row : req_ff.row;
      base_col = cmd.use_scan ? cmd.scan_col : req_ff.col;
      nb_ok    = 1'b1;
      nb_row   = base_row;
      nb_col   = base_col;
      if (rsel == 2'd0) begin
         nb_ok  = nb_ok && (base_row != '0);
         nb_row = base_row - 1'b1;
      end else if (rsel == 2'd2) begin
         nb_ok  = nb_ok && (base_row != ROW_LAST);
         nb_row = base_row + 1'b1;
      end
      if (csel == 2'd0) begin
         nb_ok  = nb_ok && (base_col != '0);
         nb_col = base_col - 1'b1;
      end else if (csel == 2'd2) begin
         nb_ok  = nb_ok && (base_col != COL_LAST);
         nb_col = base_col + 1'b1;
      end
      nb_addr = cell_addr(nb_row, nb_col);
   end

   // Cell memories
   logic [pgg_pkg::ID_W-1:0] cur_id_mem_ff  [pgg_pkg::CELL_COUNT];
   logic [pgg_pkg::EN_W-1:0] cur_en_mem_ff  [pgg_pkg::CELL_COUNT];
   logic [pgg_pkg::ID_W-1:0] snap_id_mem_ff [pgg_pkg::CELL_COUNT];
   logic [pgg_pkg::EN_W-1:0] snap_en_mem_ff [pgg_pkg::CELL_COUNT];

   logic [pgg_pkg::ID_W-1:0]   cur_id_rd_ff, snap_id_rd_ff;
   logic [pgg_pkg::EN_W-1:0]   cur_en_rd_ff, snap_en_rd_ff;
   logic [pgg_pkg::CELL_W-1:0] cur_id_ra, cur_en_ra;
   logic                       cur_id_we, cur_en_we;
   logic [pgg_pkg::CELL_W-1:0] cur_en_wa;
   logic [pgg_pkg::ID_W-1:0]   cur_id_wd;
   logic [pgg_pkg::EN_W-1:0]   cur_en_wd;
   logic                       copy_vld_ff;
   logic [pgg_pkg::CELL_W-1:0] copy_addr_ff;

   // Evaluation results
   logic [pgg_pkg::ID_W-1:0] own_id, cand_id;
   logic                     found_now, flip_now;
   logic [pgg_pkg::EN_W-1:0] cnt_own, cnt_cand;

   assign cur_id_ra = cmd.probe ? nb_addr : (cmd.copy_rd ? scan_cell : req_cell);
   assign cur_en_ra = cmd.copy_rd ? scan_cell : req_cell;

   assign cur_id_we = cmd.load_wr || (cmd.eval_visit && flip_now);
   assign cur_id_wd = cmd.load_wr ? gid_sat : cand_id;
   assign cur_en_we = cmd.eval_sweep || (cmd.eval_visit && flip_now);
   assign cur_en_wa = cmd.eval_sweep ? scan_cell : req_cell;
   assign cur_en_wd = cmd.eval_sweep ? cnt_own : cnt_cand;

   always_ff @(posedge clock) begin
      if (cur_id_we) begin
         cur_id_mem_ff[req_cell] <= cur_id_wd;
      end
      cur_id_rd_ff <= cur_id_mem_ff[cur_id_ra];
   end

   always_ff @(posedge clock) begin
      if (cur_en_we) begin
         cur_en_mem_ff[cur_en_wa] <= cur_en_wd;
      end
      cur_en_rd_ff <= cur_en_mem_ff[cur_en_ra];
   end

   // Snapshot copy writes in the cycle after the current-store read
   always_ff @(posedge clock) begin
      if (copy_vld_ff) begin
         snap_id_mem_ff[copy_addr_ff] <= cur_id_rd_ff;
      end
      snap_id_rd_ff <= snap_id_mem_ff[nb_addr];
   end

   always_ff @(posedge clock) begin
      if (copy_vld_ff) begin
         snap_en_mem_ff[copy_addr_ff] <= cur_en_rd_ff;
      end
      snap_en_rd_ff <= snap_en_mem_ff[req_cell];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         copy_vld_ff <= 1'b0;
      end else begin
         copy_vld_ff <= cmd.copy_rd;
      end
      copy_addr_ff <= scan_cell;
   end

   // Neighborhood taps, captured the cycle after each probe
   logic                     cap_vld_ff, cap_ok_ff, cap_snap_ff;
   logic [pgg_pkg::NB_W-1:0] cap_k_ff;
   logic [pgg_pkg::ID_W-1:0] tap_id_ff [pgg_pkg::NB_COUNT];
   logic [pgg_pkg::NB_COUNT-1:0] tap_ok_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_vld_ff <= 1'b0;
      end else begin
         cap_vld_ff <= cmd.probe;
      end
      cap_k_ff    <= cmd.nb_k;
      cap_ok_ff   <= nb_ok;
      cap_snap_ff <= cmd.src_snap;
      if (cap_vld_ff) begin
         tap_id_ff[cap_k_ff] <= cap_snap_ff ? snap_id_rd_ff : cur_id_rd_ff;
         tap_ok_ff[cap_k_ff] <= cap_ok_ff;
      end
   end

   // First unlike neighbor and the two unlike counts
   always_comb begin
      own_id    = tap_id_ff[pgg_pkg::NB_CENTER];
      found_now = 1'b0;
      cand_id   = '0;
      cnt_own   = '0;
      cnt_cand  = '0;
      for (int j = 0; j < pgg_pkg::NB_COUNT; j++) begin
         if (j != pgg_pkg::NB_CENTER && tap_ok_ff[j] && tap_id_ff[j] != own_id) begin
            if (!found_now) begin
               cand_id = tap_id_ff[j];
            end
            found_now = 1'b1;
            cnt_own   = cnt_own + 1'b1;
         end
      end
      for (int j = 0; j < pgg_pkg::NB_COUNT; j++) begin
         if (j != pgg_pkg::NB_CENTER && tap_ok_ff[j] && tap_id_ff[j] != cand_id) begin
            cnt_cand = cnt_cand + 1'b1;
         end
      end
      flip_now = found_now && (cnt_cand <= snap_en_rd_ff);
   end

   // Visit flags
   logic found_ff, flip_ff;

   always_ff @(posedge clock) begin
      if (cmd.take_req) begin
         found_ff <= 1'b0;
         flip_ff  <= 1'b0;
      end else if (cmd.eval_visit) begin
         found_ff <= found_now;
         flip_ff  <= flip_now;
      end
   end

   // Result register
   logic             rsp_valid_ff, rsp_valid_in;
   pgg_pkg::rsp_type rsp_data_ff, rsp_data_in;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      rsp_data_in = '0;
      if (on_grid) begin
         rsp_data_in.cell_id         = cur_id_rd_ff;
         rsp_data_in.cell_energy     = cur_en_rd_ff;
         rsp_data_in.candidate_found = found_ff;
         rsp_data_in.flipped         = flip_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd.load_rsp) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_data_ff;
   assign sts.op       = req_ff.op;
   assign sts.on_grid  = on_grid;
   assign sts.rsp_free = !rsp_valid_ff || rsp_ready;

   // Checks
   a_flip_found: assert property (@(posedge clock) disable iff (reset)
      cmd.eval_visit |=> (!flip_ff || found_ff))
      else $error("flip recorded without a candidate");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> (rsp_valid_ff && $stable(rsp_data_ff)))
      else $error("stalled result dropped or changed");

   a_load_on_grid: assert property (@(posedge clock) disable iff (reset)
      cmd.load_wr |-> on_grid)
      else $error("id written for an off-grid request");

endmodule

// File: src/potts_grain_growth_step.sv
// Potts-model grain-growth step engine: one request in, one result out.
// Req channel (req_valid/req_ready/req_data) carries op, row, col, grain_id;
// rsp channel (rsp_valid/rsp_ready/rsp_data) returns the addressed cell's
// current id and energy plus the visit flags, one result per request.
// Ops: load id, recompute all energies, visit a cell against the snapshot,
// copy current to snapshot, read a cell.
// Steps from the accepted request to result valid (single read port per store):
//   read, unused ops: dispatch, store read, result load
//   load: dispatch, id write, store read, result load
//   visit: dispatch, nine snapshot reads, capture, evaluate, read, result load
//   energy sweep: nine current reads, capture, energy write per 64 x 64 grid cell
//   snapshot copy: one cell per cycle
// One request is in flight at a time; the next is taken the cycle after the
// current result enters the output register, even while the receiver stalls it.
// A stalled result holds in the output register; a further result waits
// in the controller until the register is free.
// Reset clears control state only; cell stores are undefined until loaded.
// Depends on pgg_pkg, pgg_ctrl, pgg_datapath.
module potts_grain_growth_step (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  pgg_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output pgg_pkg::rsp_type  rsp_data
);

   pgg_pkg::cmd_type cmd;
   pgg_pkg::sts_type sts;

   // Sequencer
   pgg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Stores, evaluation and result register
   pgg_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_data  (req_data),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
